FILE: design/bchsd_pkg.sv
// Package for the button click/hold/step detector.
// Gesture codes and the one-shot fallback function; no dependencies.
package bchsd_pkg;

  typedef enum logic [3:0] {
    G_IDLE         = 4'd0,
    G_PRESS        = 4'd1,
    G_WAIT_HOLD    = 4'd2,
    G_HOLD         = 4'd3,
    G_WAIT_STEP    = 4'd4,
    G_STEP         = 4'd5,
    G_CLICK        = 4'd6,
    G_RELEASE      = 4'd7,
    G_RELEASE_HOLD = 4'd8,
    G_RELEASE_STEP = 4'd9
  } gesture_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_STEP     = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] HOLD_RST     = 16'd600;
  localparam logic [15:0] STEP_RST     = 16'd200;

  // One-shot codes last a single tick, then drop to their waiting code.
  function automatic gesture_t fall_back(input gesture_t code);
    gesture_t res;
    case (code)
      G_PRESS:     res = G_WAIT_HOLD;
      G_HOLD:      res = G_WAIT_STEP;
      G_STEP:      res = G_WAIT_STEP;
      G_IDLE:      res = G_IDLE;
      G_WAIT_HOLD: res = G_WAIT_HOLD;
      G_WAIT_STEP: res = G_WAIT_STEP;
      default:     res = G_IDLE;
    endcase
    return res;
  endfunction

endpackage

FILE: design/button_click_hold_step_detector_top.sv
// Top level of the button click/hold/step detector.
// Uses bchsd_pkg for gesture codes, register indexes and reset values.
//
// Each input beat is one tick: the raw button level and a free-running
// millisecond time. The block debounces the level (a changed level must
// persist debounce_ms, measured from the first differing tick), then tracks
// press, hold after hold_ms, repeated steps every step_ms, click and the
// three release kinds. Every input beat yields exactly one output beat with
// an event flag and the current gesture code; one-shot codes fall back to
// their waiting code on the next tick. Time differences wrap modulo 2^32.
// Throughput is one beat per clock while out_stall is low; a beat passes
// an input register, then the output register. The gesture state is updated in
// the single cycle an item moves from the input register to the output
// register, which is what sets the one-per-clock rate. in_stall rises only
// when the input register is full and the output register cannot drain.
// Configuration writes are always ready (cfg_ready is tied high); index 3
// is ignored. Write only while no beats are in flight.
module button_click_hold_step_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_pin_level,
  input  logic [31:0] in_time_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_res,
  output logic [3:0]  out_gesture,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] debounce_ms_r;
  logic [15:0] hold_ms_r;
  logic [15:0] step_ms_r;

  // input stage
  logic        s1_valid_r;
  logic        s1_level_r;
  logic [31:0] s1_time_r;

  // tracker state
  bchsd_pkg::gesture_t gesture_r, gesture_nxt;
  logic        level_r, level_nxt;
  logic        dbn_run_r, dbn_run_nxt;
  logic [31:0] dbn_start_r, dbn_start_nxt;
  logic [31:0] phase_start_r, phase_start_nxt;
  logic        stepping_r, stepping_nxt;
  logic        event_nxt;

  // output stage
  logic        out_valid_r;
  logic        out_event_r, out_event_nxt;
  logic [3:0]  out_gesture_r, out_gesture_nxt;

  logic        adv;
  logic [31:0] dbn_elapsed;
  logic [31:0] phase_elapsed;

  // item moves on when the output register is empty or being drained
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= bchsd_pkg::DEBOUNCE_RST;
      hold_ms_r     <= bchsd_pkg::HOLD_RST;
      step_ms_r     <= bchsd_pkg::STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bchsd_pkg::CFG_DEBOUNCE: debounce_ms_r <= cfg_data;
        bchsd_pkg::CFG_HOLD:     hold_ms_r     <= cfg_data;
        bchsd_pkg::CFG_STEP:     step_ms_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_level_r <= in_pin_level;
      s1_time_r  <= in_time_ms;
    end
  end

  assign dbn_elapsed   = s1_time_r - dbn_start_r;
  assign phase_elapsed = s1_time_r - phase_start_r;

  // next state of the tracker
  always_comb begin
    gesture_nxt     = bchsd_pkg::fall_back(gesture_r);
    level_nxt       = level_r;
    dbn_run_nxt     = dbn_run_r;
    dbn_start_nxt   = dbn_start_r;
    phase_start_nxt = phase_start_r;
    stepping_nxt    = stepping_r;
    event_nxt       = 1'b0;

    if (s1_level_r != level_r) begin
      if (!dbn_run_r) begin
        // first differing tick only starts the debounce timer
        dbn_start_nxt = s1_time_r;
        dbn_run_nxt   = 1'b1;
      end else if (dbn_elapsed >= {16'd0, debounce_ms_r}) begin
        level_nxt   = s1_level_r;
        dbn_run_nxt = 1'b0;
        event_nxt   = 1'b1;
        if (s1_level_r) begin
          gesture_nxt     = bchsd_pkg::G_PRESS;
          phase_start_nxt = s1_time_r;
          stepping_nxt    = 1'b0;
        end else if (stepping_r) begin
          gesture_nxt = bchsd_pkg::G_RELEASE_STEP;
        end else if (gesture_nxt == bchsd_pkg::G_WAIT_STEP) begin
          gesture_nxt = bchsd_pkg::G_RELEASE_HOLD;
        end else if (gesture_nxt == bchsd_pkg::G_WAIT_HOLD) begin
          gesture_nxt = bchsd_pkg::G_CLICK;
        end else begin
          gesture_nxt = bchsd_pkg::G_RELEASE;
        end
      end
    end else begin
      dbn_run_nxt = 1'b0;
    end

    // hold and step timing while pressed
    if (!event_nxt && level_nxt) begin
      if (gesture_nxt == bchsd_pkg::G_WAIT_HOLD) begin
        if (phase_elapsed >= {16'd0, hold_ms_r}) begin
          gesture_nxt     = bchsd_pkg::G_HOLD;
          phase_start_nxt = s1_time_r;
          event_nxt       = 1'b1;
        end
      end else if (gesture_nxt == bchsd_pkg::G_WAIT_STEP) begin
        if (phase_elapsed >= {16'd0, step_ms_r}) begin
          gesture_nxt     = bchsd_pkg::G_STEP;
          stepping_nxt    = 1'b1;
          phase_start_nxt = s1_time_r;
          event_nxt       = 1'b1;
        end
      end
    end
  end

  // output beat contents
  always_comb begin
    out_event_nxt   = event_nxt;
    out_gesture_nxt = 4'(gesture_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gesture_r     <= bchsd_pkg::G_IDLE;
      level_r       <= 1'b0;
      dbn_run_r     <= 1'b0;
      dbn_start_r   <= 32'd0;
      phase_start_r <= 32'd0;
      stepping_r    <= 1'b0;
    end else if (adv) begin
      gesture_r     <= gesture_nxt;
      level_r       <= level_nxt;
      dbn_run_r     <= dbn_run_nxt;
      dbn_start_r   <= dbn_start_nxt;
      phase_start_r <= phase_start_nxt;
      stepping_r    <= stepping_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_event_r   <= out_event_nxt;
      out_gesture_r <= out_gesture_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_gesture   = out_gesture_r;

`ifndef SYNTHESIS
  // event flag is raised exactly on one-shot codes
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_event_r == !(out_gesture_r == 4'(bchsd_pkg::G_IDLE) ||
                                      out_gesture_r == 4'(bchsd_pkg::G_WAIT_HOLD) ||
                                      out_gesture_r == 4'(bchsd_pkg::G_WAIT_STEP))))
    else $error("event flag disagrees with gesture code");

  // press-side codes only while the accepted level is pressed
  a_pressed_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (gesture_r == bchsd_pkg::G_PRESS || gesture_r == bchsd_pkg::G_WAIT_HOLD ||
     gesture_r == bchsd_pkg::G_HOLD || gesture_r == bchsd_pkg::G_WAIT_STEP ||
     gesture_r == bchsd_pkg::G_STEP) |-> level_r)
    else $error("pressed gesture with released level");

  // stepping is cleared on press, so never seen before the first hold
  a_no_step_before_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (gesture_r == bchsd_pkg::G_WAIT_HOLD || gesture_r == bchsd_pkg::G_PRESS)
      |-> !stepping_r)
    else $error("stepping set while waiting for hold");

  // back-pressure only with a full input register and a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");
`endif

endmodule

FILE: test/button_click_hold_step_detector_top_test.sv
// Testbench for button_click_hold_step_detector_top: directed and random ticks, scored
// beat by beat against an in-bench gesture predictor. Uses bchsd_pkg and the RTL only.
`timescale 1ns / 1ps

module button_click_hold_step_detector_top_test;

  // Index 3 exists on the 2-bit bus but maps to no register.
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_OFF_LEN = 300;   // long receiver stall, in cycles
  localparam int         PHASE_TICKS  = 220;

  // Expected output beat for one tick.
  typedef struct packed {
    logic                ev;
    bchsd_pkg::gesture_t g;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_pin_level = 1'b0;
  logic [31:0] in_time_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_event_res;
  logic [3:0]  out_gesture;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Gesture predictor state, reset values of the block.
  logic [15:0]         debounce_ms = bchsd_pkg::DEBOUNCE_RST;
  logic [15:0]         hold_ms     = bchsd_pkg::HOLD_RST;
  logic [15:0]         step_ms     = bchsd_pkg::STEP_RST;
  bchsd_pkg::gesture_t cur_gesture = bchsd_pkg::G_IDLE;
  logic [31:0]         bounce_start = '0;
  logic                bounce_running = 1'b0;
  logic [31:0]         phase_start = '0;
  logic                pressed = 1'b0;
  logic                stepping = 1'b0;

  tick_result_t expected_ticks[$];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  logic [31:0] now_ms = '0;
  bit          idle_on = 1'b1;     // random idling on both channels
  int unsigned hold_off_reqs = 0;  // bumped by a test to ask for a long stall
  int unsigned hold_off_seen = 0;
  int unsigned hold_off_left = 0;

  button_click_hold_step_detector_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pin_level (in_pin_level),
    .in_time_ms   (in_time_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_event_res(out_event_res),
    .out_gesture  (out_gesture),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("cycle limit hit, %0d results still expected", expected_ticks.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // One tick through the gesture tracker. Order matters: one-shot codes drop
  // to their waiting code first, then debounce, then hold/step timing, which
  // only runs when the tick raised no press or release.
  function automatic void predict_tick(input logic level, input logic [31:0] now);
    tick_result_t res;
    logic         ev;
    logic [31:0]  elapsed;
    ev = 1'b0;
    case (cur_gesture)
      bchsd_pkg::G_PRESS:
        cur_gesture = bchsd_pkg::G_WAIT_HOLD;
      bchsd_pkg::G_HOLD, bchsd_pkg::G_STEP:
        cur_gesture = bchsd_pkg::G_WAIT_STEP;
      bchsd_pkg::G_IDLE, bchsd_pkg::G_WAIT_HOLD, bchsd_pkg::G_WAIT_STEP:
        cur_gesture = cur_gesture;
      default:
        cur_gesture = bchsd_pkg::G_IDLE;
    endcase
    if (level != pressed) begin
      // First differing tick only starts the timer, even with zero debounce.
      if (!bounce_running) begin
        bounce_start   = now;
        bounce_running = 1'b1;
      end else if (now - bounce_start >= {16'd0, debounce_ms}) begin
        pressed        = level;
        bounce_running = 1'b0;
        ev             = 1'b1;
        if (level) begin
          cur_gesture = bchsd_pkg::G_PRESS;
          phase_start = now;
          stepping    = 1'b0;
        end else if (stepping) begin
          // stepping stays set after release until the next press
          cur_gesture = bchsd_pkg::G_RELEASE_STEP;
        end else if (cur_gesture == bchsd_pkg::G_WAIT_STEP) begin
          cur_gesture = bchsd_pkg::G_RELEASE_HOLD;
        end else if (cur_gesture == bchsd_pkg::G_WAIT_HOLD) begin
          cur_gesture = bchsd_pkg::G_CLICK;
        end else begin
          cur_gesture = bchsd_pkg::G_RELEASE;
        end
      end
    end else begin
      bounce_running = 1'b0;
    end
    if (!ev && pressed) begin
      elapsed = now - phase_start;  // wraps modulo 2^32
      if (cur_gesture == bchsd_pkg::G_WAIT_HOLD && elapsed >= {16'd0, hold_ms}) begin
        cur_gesture = bchsd_pkg::G_HOLD;
        phase_start = now;
        ev          = 1'b1;
      end else if (cur_gesture == bchsd_pkg::G_WAIT_STEP &&
                   elapsed >= {16'd0, step_ms}) begin
        cur_gesture = bchsd_pkg::G_STEP;
        stepping    = 1'b1;
        phase_start = now;
        ev          = 1'b1;
      end
    end
    res.ev = ev;
    res.g  = cur_gesture;
    expected_ticks.push_back(res);
  endfunction

  // Input monitor: every accepted beat feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_tick(in_pin_level, in_time_ms);
  end

  // Result checker: each accepted output beat against the oldest expectation.
  always @(posedge clk) begin : check_beat
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch($sformatf("result beat ev=%0d gesture=%0d with nothing expected",
                                  out_event_res, out_gesture));
      end else begin
        want = expected_ticks.pop_front();
        results_seen++;
        if (out_event_res !== want.ev)
          report_mismatch($sformatf("event_res %0b, expected %0b (gesture %0d)",
                                    out_event_res, want.ev, want.g));
        if (out_gesture !== want.g)
          report_mismatch($sformatf("gesture %0d, expected %0d", out_gesture, want.g));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= HOLD_OFF_LEN;
      out_stall     <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 25);
    end
  end

  // Offer one tick beat, with random idle cycles in front; returns once the
  // beat is taken. Valid stays high into the next call's negedge.
  task automatic send_tick(input logic level, input logic [31:0] t);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= level;
    in_time_ms   <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Advance the clock-of-day by up to max_step ms (rarely a wild jump) and send.
  task automatic tick(input logic level, input int unsigned max_step);
    if ($urandom_range(63) == 0) now_ms = now_ms + $urandom;
    else                         now_ms = now_ms + $urandom_range(max_step, 0);
    send_tick(level, now_ms);
  endtask

  // Drop valid and let every in-flight beat come out before touching config.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bchsd_pkg::CFG_DEBOUNCE: debounce_ms = val;
      bchsd_pkg::CFG_HOLD:     hold_ms     = val;
      bchsd_pkg::CFG_STEP:     step_ms     = val;
      default:                 ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] db, input logic [15:0] hd,
                            input logic [15:0] st);
    drain();
    write_reg(bchsd_pkg::CFG_DEBOUNCE, db);
    write_reg(bchsd_pkg::CFG_HOLD, hd);
    write_reg(bchsd_pkg::CFG_STEP, st);
  endtask

  // One plausible gesture: contact bounce, a press of random length, then a
  // bouncy release. Press length spans clicks, holds and long step runs.
  task automatic play_gesture(input int unsigned max_step);
    int unsigned n;
    n = $urandom_range(3, 0);
    repeat (n) tick(1'($urandom_range(1, 0)), max_step);
    n = $urandom_range(40, 1);
    repeat (n) tick(1'b1, max_step);
    n = $urandom_range(2, 0);
    repeat (n) tick(1'($urandom_range(1, 0)), max_step);
    n = $urandom_range(15, 1);
    repeat (n) tick(1'b0, max_step);
  endtask

  // Reset timings: debounce threshold edge, hold, step, bounce that stops the
  // timer, and release after stepping.
  task automatic test_reset_timing;
    send_tick(1'b0, 32'd0);
    send_tick(1'b1, 32'd10);   // starts the debounce timer
    send_tick(1'b1, 32'd59);   // one short of debounce
    send_tick(1'b1, 32'd60);   // press
    send_tick(1'b1, 32'd61);
    send_tick(1'b1, 32'd660);  // hold exactly at hold_ms
    send_tick(1'b1, 32'd860);  // step exactly at step_ms
    send_tick(1'b0, 32'd861);
    send_tick(1'b1, 32'd870);  // bounce back, debounce timer stops
    send_tick(1'b0, 32'd880);
    send_tick(1'b0, 32'd930);  // release after stepping
  endtask

  // Zero debounce, tiny hold, widest step, time wrapping past all ones,
  // and a write to the unused index that must change nothing.
  task automatic test_zero_debounce_wrap;
    set_timing(16'd0, 16'd3, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_tick(1'b1, 32'hFFFF_FFFE);  // first differing tick still only arms
    send_tick(1'b1, 32'hFFFF_FFFF);  // press
    send_tick(1'b1, 32'd0);
    send_tick(1'b1, 32'd2);          // hold across the wrap
    send_tick(1'b1, 32'd5);
    send_tick(1'b0, 32'd6);
    send_tick(1'b0, 32'd6);          // release after hold
    send_tick(1'b1, 32'd7);
    send_tick(1'b1, 32'd7);          // press
    send_tick(1'b0, 32'd8);
    send_tick(1'b0, 32'd8);          // click
    send_tick(1'b0, 32'd9);
    now_ms = 32'd9;
  endtask

  // Random phases, each under its own timing. The first two are the extremes;
  // the rest use short timings so holds and step runs come often.
  task automatic test_random_gestures;
    int unsigned start_cnt;
    int unsigned max_step;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        set_timing(16'd0, 16'd0, 16'd0);
        max_step = 5;
      end else if (p == 1) begin
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        max_step = 50000;
      end else begin
        set_timing(16'($urandom_range(20, 0)), 16'($urandom_range(120, 0)),
                   16'($urandom_range(60, 0)));
        max_step = $urandom_range(40, 1);
      end
      now_ms    = $urandom;
      start_cnt = ticks_sent;
      while (ticks_sent - start_cnt < PHASE_TICKS) begin
        if ($urandom_range(7) == 0) begin
          // noise: any level at any time
          repeat ($urandom_range(6, 1)) send_tick(1'($urandom_range(1, 0)), $urandom);
        end else begin
          play_gesture(max_step);
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while ticks keep coming, so the
  // block fills and has to stall its input.
  task automatic test_backpressure;
    set_timing(16'd4, 16'd30, 16'd10);
    hold_off_reqs++;
    repeat (40) tick(1'($urandom_range(1, 0)), 8);
  endtask

  // No idling on either side: back-to-back beats at full rate.
  task automatic test_steady_stream;
    int unsigned start_cnt;
    set_timing(16'd3, 16'd40, 16'd15);
    idle_on   = 1'b0;
    start_cnt = ticks_sent;
    while (ticks_sent - start_cnt < 200) play_gesture(10);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_timing();
    test_zero_debounce_wrap();
    test_random_gestures();
    test_backpressure();
    test_steady_stream();

    drain();
    repeat (10) @(posedge clk);
    if (expected_ticks.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));

    $display("summary: %0d ticks sent, %0d results checked, %0d register writes",
             ticks_sent, results_seen, cfg_writes);
    $display("summary: covered debounce, click, hold, step runs, wrap, stalls, %0d mismatches",
             errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
